>>> design/scn_pkg.sv
// package: widths, constants and per-stage types for the coherency normalizer
`default_nettype none
package scn_pkg;
    localparam int IN_WIDTH  = 32;
    localparam int OUT_FRAC  = 16;
    localparam int OUT_WIDTH = OUT_FRAC + 2;
    localparam int PW        = 2 * IN_WIDTH;
    localparam int SW        = IN_WIDTH;
    localparam int QW        = OUT_FRAC + 4;
    localparam int RW        = IN_WIDTH + 1;
    localparam int SQ_CELLS  = IN_WIDTH;
    localparam int DV_CELLS  = OUT_FRAC + 4;
    localparam int DIV_INT   = 3;

    typedef struct packed {
        logic                 vld;
        logic                 inv;
        logic                 neg_re;
        logic                 neg_im;
        logic [IN_WIDTH-1:0]  mag_re;
        logic [IN_WIDTH-1:0]  mag_im;
        logic [PW-1:0]        rem;
        logic [SW-1:0]        root;
        logic [PW-1:0]        prod;
    } t_sq;

    typedef struct packed {
        logic                 vld;
        logic                 inv;
        logic                 neg_re;
        logic                 neg_im;
        logic [SW-1:0]        root;
        logic [RW-1:0]        rem_re;
        logic [RW-1:0]        rem_im;
        logic [QW-1:0]        q_re;
        logic [QW-1:0]        q_im;
    } t_dv;

    function automatic logic [IN_WIDTH-1:0] f_mag(input logic [IN_WIDTH-1:0] x);
        f_mag = x[IN_WIDTH-1] ? (~x + 1'b1) : x;
    endfunction
endpackage
`default_nettype wire

>>> design/scn_sqrt_cell.sv
// one bit of the restoring square root, registered
`default_nettype none
module scn_sqrt_cell (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire scn_pkg::t_sq i_d,
    output scn_pkg::t_sq      o_d
);
    import scn_pkg::*;
    t_sq r_d, n_d;
    logic [SW+1:0] w_r, w_t;
    always_comb begin
        n_d = i_d;
        w_r = {i_d.rem[SW-1:0], i_d.prod[PW-1:PW-2]};
        w_t = {i_d.root, 2'b01};
        n_d.prod = {i_d.prod[PW-3:0], 2'b00};
        if (w_r >= w_t) begin
            n_d.rem = PW'(w_r - w_t);
            n_d.root = {i_d.root[SW-2:0], 1'b1};
        end else begin
            n_d.rem = PW'(w_r);
            n_d.root = {i_d.root[SW-2:0], 1'b0};
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d.vld <= 1'b0;
        else r_d.vld <= n_d.vld;
        r_d[$bits(t_sq)-2:0] <= n_d[$bits(t_sq)-2:0];
    end
    assign o_d = r_d;
endmodule
`default_nettype wire

>>> design/scn_div_cell.sv
// one quotient bit of both restoring divisions, registered
`default_nettype none
module scn_div_cell (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_first,
    input  wire scn_pkg::t_dv i_d,
    output scn_pkg::t_dv      o_d
);
    import scn_pkg::*;
    t_dv r_d, n_d;
    logic [RW:0] w_re, w_im, w_s;
    always_comb begin
        n_d = i_d;
        w_s = {2'b0, i_d.root};
        w_re = i_first ? {1'b0, i_d.rem_re} : {i_d.rem_re, 1'b0};
        w_im = i_first ? {1'b0, i_d.rem_im} : {i_d.rem_im, 1'b0};
        n_d.q_re = {i_d.q_re[QW-2:0], w_re >= w_s};
        n_d.q_im = {i_d.q_im[QW-2:0], w_im >= w_s};
        n_d.rem_re = (w_re >= w_s) ? RW'(w_re - w_s) : w_re[RW-1:0];
        n_d.rem_im = (w_im >= w_s) ? RW'(w_im - w_s) : w_im[RW-1:0];
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d.vld <= 1'b0;
        else r_d.vld <= n_d.vld;
        r_d[$bits(t_dv)-2:0] <= n_d[$bits(t_dv)-2:0];
    end
    assign o_d = r_d;
endmodule
`default_nettype wire

>>> design/spectral_coherency_normalizer.sv
// top level: coherency of a cross spectrum normalized by the auto spectra
// channel | signals                                         | dir
// input   | i_start, o_busy, i_cross_re/im, i_auto_first/.. | in
// result  | o_strobe, o_coh_re/im, o_invalid, o_saturated   | out
// one item per cycle; o_busy is always low outside reset
// stages: input register, 32 root cells, 20 divide cells, output register
// reset clears the valid bits of every cell; results cannot be stalled
`default_nettype none
module spectral_coherency_normalizer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    output logic                               o_busy,
    input  wire logic [scn_pkg::IN_WIDTH-1:0]  i_cross_re,
    input  wire logic [scn_pkg::IN_WIDTH-1:0]  i_cross_im,
    input  wire logic [scn_pkg::IN_WIDTH-1:0]  i_auto_first,
    input  wire logic [scn_pkg::IN_WIDTH-1:0]  i_auto_second,
    output logic                               o_strobe,
    output logic signed [scn_pkg::OUT_WIDTH-1:0] o_coh_re,
    output logic signed [scn_pkg::OUT_WIDTH-1:0] o_coh_im,
    output logic                               o_invalid,
    output logic                               o_saturated
);
    import scn_pkg::*;
    t_sq r_in, n_in;
    t_sq w_sq [0:SQ_CELLS];
    t_dv w_dv [0:DV_CELLS];
    logic [IN_WIDTH-1:0] w_a1, w_a2;
    logic [QW-1:0] w_mre, w_mim;
    logic w_sre, w_sim;
    logic [OUT_WIDTH-1:0] w_ore, w_oim;
    logic r_stb, r_inv, r_sat;
    logic [OUT_WIDTH-1:0] r_re, r_im;

    assign o_busy = !i_rst_n;

    always_comb begin
        w_a1 = f_mag(i_auto_first);
        w_a2 = f_mag(i_auto_second);
        n_in.vld = i_start;
        n_in.inv = (w_a1 == '0) || (w_a2 == '0)
                   || (i_auto_first[IN_WIDTH-1] != i_auto_second[IN_WIDTH-1]);
        n_in.neg_re = i_cross_re[IN_WIDTH-1];
        n_in.neg_im = i_cross_im[IN_WIDTH-1];
        n_in.mag_re = f_mag(i_cross_re);
        n_in.mag_im = f_mag(i_cross_im);
        n_in.rem = '0;
        n_in.root = '0;
        n_in.prod = PW'(w_a1) * PW'(w_a2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_in.vld <= 1'b0;
        else r_in.vld <= n_in.vld;
        r_in[$bits(t_sq)-2:0] <= n_in[$bits(t_sq)-2:0];
    end

    assign w_sq[0] = r_in;

    for (genvar g = 0; g < SQ_CELLS; g++) begin : g_sq
        scn_sqrt_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_d(w_sq[g]), .o_d(w_sq[g+1])
        );
    end

    always_comb begin
        w_dv[0].vld = w_sq[SQ_CELLS].vld;
        w_dv[0].inv = w_sq[SQ_CELLS].inv;
        w_dv[0].neg_re = w_sq[SQ_CELLS].neg_re;
        w_dv[0].neg_im = w_sq[SQ_CELLS].neg_im;
        w_dv[0].root = (w_sq[SQ_CELLS].root == '0) ? SW'(1) : w_sq[SQ_CELLS].root;
        w_dv[0].rem_re = {1'b0, w_sq[SQ_CELLS].mag_re};
        w_dv[0].rem_im = {1'b0, w_sq[SQ_CELLS].mag_im};
        w_dv[0].q_re = '0;
        w_dv[0].q_im = '0;
    end

    // first three cells give integer bits (clamped below), the rest fraction bits
    for (genvar g = 0; g < DV_CELLS; g++) begin : g_dv
        if (g < DIV_INT) begin : g_int
            scn_div_cell u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_first(1'b1),
                .i_d(w_dv[g]), .o_d(w_dv[g+1])
            );
        end else begin : g_frac
            scn_div_cell u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_first(1'b0),
                .i_d(w_dv[g]), .o_d(w_dv[g+1])
            );
        end
    end

    // integer cells subtract without shift: q bits count 0..3 as 3 unary bits
    function automatic logic [QW-1:0] f_round(input logic [QW-1:0] q);
        logic [1:0] qi;
        logic [QW:0] t;
        qi = {1'b0, q[QW-1]} + {1'b0, q[QW-2]} + {1'b0, q[QW-3]};
        t = {qi, q[QW-4:0]} + 1'b1;
        f_round = t[QW:1];
    endfunction

    function automatic logic [OUT_WIDTH-1:0] f_clip(
        input logic [QW-1:0] m, input logic neg, output logic sat);
        logic [QW-1:0] lim;
        logic [QW-1:0] mm;
        lim = neg ? QW'(1) << (OUT_FRAC + 1) : (QW'(1) << (OUT_FRAC + 1)) - 1'b1;
        sat = m > lim;
        mm = sat ? lim : m;
        f_clip = neg ? OUT_WIDTH'(~mm + 1'b1) : mm[OUT_WIDTH-1:0];
    endfunction

    always_comb begin
        w_mre = f_round(w_dv[DV_CELLS].q_re);
        w_mim = f_round(w_dv[DV_CELLS].q_im);
        w_ore = f_clip(w_mre, w_dv[DV_CELLS].neg_re, w_sre);
        w_oim = f_clip(w_mim, w_dv[DV_CELLS].neg_im, w_sim);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_stb <= 1'b0;
        else r_stb <= w_dv[DV_CELLS].vld;
        r_inv <= w_dv[DV_CELLS].inv;
        r_sat <= !w_dv[DV_CELLS].inv && (w_sre || w_sim);
        r_re <= w_dv[DV_CELLS].inv ? '0 : w_ore;
        r_im <= w_dv[DV_CELLS].inv ? '0 : w_oim;
    end

    assign o_strobe = r_stb;
    assign o_coh_re = r_re;
    assign o_coh_im = r_im;
    assign o_invalid = r_inv;
    assign o_saturated = r_sat;
endmodule
`default_nettype wire

>>> tb/tb_spectral_coherency_normalizer_chk.sv
// checker: predicts coherency results from accepted commands and compares them
module tb_spectral_coherency_normalizer_chk (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic                           i_busy,
    input  wire logic [scn_pkg::IN_WIDTH-1:0]   i_cross_re,
    input  wire logic [scn_pkg::IN_WIDTH-1:0]   i_cross_im,
    input  wire logic [scn_pkg::IN_WIDTH-1:0]   i_auto_first,
    input  wire logic [scn_pkg::IN_WIDTH-1:0]   i_auto_second,
    input  wire logic                           i_strobe,
    input  wire logic [scn_pkg::OUT_WIDTH-1:0]  i_coh_re,
    input  wire logic [scn_pkg::OUT_WIDTH-1:0]  i_coh_im,
    input  wire logic                           i_invalid,
    input  wire logic                           i_saturated,
    output int                                  o_errors,
    output int                                  o_pending,
    output int                                  o_results,
    output int                                  o_invalids,
    output int                                  o_sats
);
    timeunit 1ns;
    timeprecision 1ps;
    import scn_pkg::*;

    typedef struct packed {
        logic [OUT_WIDTH-1:0] re;
        logic [OUT_WIDTH-1:0] im;
        logic                 inv;
        logic                 sat;
    } t_coh;

    t_coh coh_q[$];

    function automatic logic [IN_WIDTH-1:0] abs_val(input logic [IN_WIDTH-1:0] x,
                                                   output logic neg);
        neg = x[IN_WIDTH-1];
        return neg ? IN_WIDTH'(-x) : x;
    endfunction

    function automatic logic [OUT_WIDTH-1:0] norm_part(input logic [IN_WIDTH-1:0] raw,
                                                      input logic [127:0] root,
                                                      inout logic sat);
        logic neg;
        logic [127:0] mag;
        logic [127:0] m;
        mag = 128'(abs_val(raw, neg));
        m = ((mag << (OUT_FRAC + 1)) / root + 1) >> 1;
        if (neg) begin
            if (m > (128'd1 << (OUT_FRAC + 1))) begin
                m = 128'd1 << (OUT_FRAC + 1);
                sat = 1'b1;
            end
            return OUT_WIDTH'(-m);
        end
        if (m > (128'd1 << (OUT_FRAC + 1)) - 1) begin
            m = (128'd1 << (OUT_FRAC + 1)) - 1;
            sat = 1'b1;
        end
        return OUT_WIDTH'(m);
    endfunction

    function automatic t_coh predict_coh(input logic [IN_WIDTH-1:0] cre, cim, a1, a2);
        t_coh r;
        logic n1, n2;
        logic [127:0] m1, m2, prod, root, t;
        m1 = 128'(abs_val(a1, n1));
        m2 = 128'(abs_val(a2, n2));
        r = '0;
        if (m1 == 0 || m2 == 0 || n1 != n2) begin
            r.inv = 1'b1;
            return r;
        end
        prod = m1 * m2;
        root = 0;
        for (int b = IN_WIDTH - 1; b >= 0; b--) begin
            t = root | (128'd1 << b);
            if (t * t <= prod) root = t;
        end
        r.re = norm_part(cre, root, r.sat);
        r.im = norm_part(cim, root, r.sat);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [OUT_WIDTH-1:0] got,
                                   input logic [OUT_WIDTH-1:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        o_errors++;
    endtask

    assign o_pending = coh_q.size();

    initial begin
        o_errors = 0;
        o_results = 0;
        o_invalids = 0;
        o_sats = 0;
    end

    always @(posedge i_clk) begin
        t_coh want;
        if (i_rst_n) begin
            if (i_start && !i_busy)
                coh_q.push_back(predict_coh(i_cross_re, i_cross_im, i_auto_first,
                                            i_auto_second));
            if (i_strobe) begin
                o_results++;
                if (coh_q.size() == 0) begin
                    report_mismatch("unexpected transfer", '0, '0);
                end else begin
                    want = coh_q.pop_front();
                    if (want.inv) o_invalids++;
                    if (want.sat) o_sats++;
                    if (i_coh_re !== want.re) report_mismatch("coh_re", i_coh_re, want.re);
                    if (i_coh_im !== want.im) report_mismatch("coh_im", i_coh_im, want.im);
                    if (i_invalid !== want.inv)
                        report_mismatch("invalid", OUT_WIDTH'(i_invalid), OUT_WIDTH'(want.inv));
                    if (i_saturated !== want.sat)
                        report_mismatch("saturated", OUT_WIDTH'(i_saturated),
                                        OUT_WIDTH'(want.sat));
                end
            end
        end
    end
endmodule

>>> tb/tb_spectral_coherency_normalizer.sv
// testbench top: drives coherency commands and reports the verdict
module tb_spectral_coherency_normalizer;
    timeunit 1ns;
    timeprecision 1ps;
    import scn_pkg::*;

    logic i_clk, i_rst_n, i_start;
    logic [IN_WIDTH-1:0] i_cross_re, i_cross_im, i_auto_first, i_auto_second;
    logic o_busy, o_strobe, o_invalid, o_saturated;
    logic signed [OUT_WIDTH-1:0] o_coh_re, o_coh_im;
    int errors, pending, results, invalids, sats;
    int sent;

    spectral_coherency_normalizer dut (.*);

    tb_spectral_coherency_normalizer_chk chk (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_cross_re, .i_cross_im,
        .i_auto_first, .i_auto_second, .i_strobe(o_strobe), .i_coh_re(o_coh_re),
        .i_coh_im(o_coh_im), .i_invalid(o_invalid), .i_saturated(o_saturated),
        .o_errors(errors), .o_pending(pending), .o_results(results),
        .o_invalids(invalids), .o_sats(sats)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("** spectral_coherency_normalizer: FAILED **");
        $finish;
    end

    function automatic logic [IN_WIDTH-1:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return IN_WIDTH'($urandom_range(0, 255));
            2: return -IN_WIDTH'($urandom_range(0, 255));
            3: return IN_WIDTH'($urandom_range(1, 3)) << $urandom_range(0, 31);
            4: return {1'b1, 31'($urandom())};
            default: return IN_WIDTH'($urandom_range(0, 65535)) << $urandom_range(0, 16);
        endcase
    endfunction

    task automatic send(input logic [IN_WIDTH-1:0] cre, cim, a1, a2, input bit idle);
        if (idle) begin
            while ($urandom_range(0, 99) < 38) begin
                i_start <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_start <= 1'b1;
        i_cross_re <= cre;
        i_cross_im <= cim;
        i_auto_first <= a1;
        i_auto_second <= a2;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        sent++;
    endtask

    // coherent item: cross and auto magnitudes drawn at one shared random scale
    task automatic send_shaped(input bit idle);
        logic [IN_WIDTH-1:0] a1, a2, c;
        int sh;
        sh = $urandom_range(0, 14);
        a1 = IN_WIDTH'($urandom_range(1, 32'h7fff)) << sh;
        a2 = IN_WIDTH'($urandom_range(1, 32'h7fff)) << sh;
        c = IN_WIDTH'($urandom_range(0, 32'h7fff)) << sh;
        if ($urandom_range(0, 3) == 0) begin
            a1 = -a1;
            a2 = -a2;
        end
        send($urandom_range(0, 1) ? c : -c, $urandom_range(0, 1) ? c >> 1 : -(c >> 2),
             a1, a2, idle);
    endtask

    initial begin
        logic [IN_WIDTH-1:0] mx, mn, one;
        mx = {1'b0, {(IN_WIDTH-1){1'b1}}};
        mn = {1'b1, {(IN_WIDTH-1){1'b0}}};
        one = IN_WIDTH'(1) << 16;
        sent = 0;
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_cross_re <= '0;
        i_cross_im <= '0;
        i_auto_first <= '0;
        i_auto_second <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners
        send(one, one, one, one, 1'b0);
        send(-one, one >> 1, one, one, 1'b0);
        send(mx, mn, one, one, 1'b0);
        send(mx, mn, 1, 1, 1'b0);
        send(mn, mx, mx, mx, 1'b0);
        send(mn, mn, mn, mn, 1'b0);
        send(one, -one, -one, -one, 1'b0);
        send(one, one, 0, one, 1'b0);
        send(one, one, one, 0, 1'b0);
        send(one, one, -one, one, 1'b0);
        send(one, one, one, mn, 1'b0);
        send(0, 0, 0, 0, 1'b0);
        send(IN_WIDTH'(2), -IN_WIDTH'(2), IN_WIDTH'(4), IN_WIDTH'(1), 1'b0);
        send(IN_WIDTH'(3), -IN_WIDTH'(3), IN_WIDTH'(4), IN_WIDTH'(1), 1'b0);
        send(one << 1, -(one << 1), one, one, 1'b0);
        send(-(one << 1) - 1, (one << 1) - 1, one, one, 1'b0);
        send(mx, mx, mx, 1, 1'b0);
        send(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 1'b0);
        send(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 1'b0);

        // random: first burst without gaps, then random idle gaps, with a full drain halfway
        for (int k = 0; k < 500; k++) begin
            if (k == 250) begin
                i_start <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            if ($urandom_range(0, 99) < 70) send_shaped(k >= 120);
            else send(rand_word(), rand_word(), rand_word(), rand_word(), k >= 120);
        end
        i_start <= 1'b0;

        for (int w = 0; w < 2000 && pending != 0; w++) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("sent %0d commands, checked %0d results", sent, results);
        $display("invalid results %0d, saturated results %0d", invalids, sats);
        if (errors == 0 && pending == 0) begin
            $display("** spectral_coherency_normalizer: PASSED **");
        end else begin
            $display("** spectral_coherency_normalizer: FAILED **");
        end
        $finish;
    end
endmodule
